// ----- sv/pwd_pkg.sv -----
// pwd_pkg: shared widths, codes, reset values and control structs of the
// peak window detector. No dependencies; every other file but pwd_ram uses it.
package pwd_pkg;

	localparam int DATA_W = 8;   // pixel width
	localparam int DIM_W  = 12;  // frame size registers and configuration data
	localparam int ROW_W  = 20;  // input row counter
	localparam int Q_W    = 32;  // raster index of the next input item
	localparam int POS_W  = 23;  // raster index of the next result
	localparam int OROW_W = 22;  // row of the next result
	localparam int TOT_W  = 24;  // pixels per frame
	localparam int WORD_W = 2 * DATA_W; // line store word: middle line above upper line

	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

	// input item kinds
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd20;
	localparam logic [DIM_W-1:0]  WIDTH_RESET     = 12'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 12'd480;
	localparam logic [DIM_W-1:0]  MIN_DIM         = 12'd3;

	localparam logic [DATA_W-1:0] PIX_PEAK = 8'd255;
	localparam logic [DATA_W-1:0] PIX_NONE = 8'd0;

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	// per-item control, decided at acceptance
	typedef struct packed {
		logic act;     // item updates line stores and window
		logic zero;    // frame already complete: feed a zero pixel
		logic emit;    // item releases one result
		logic last;    // that result closes the frame
		logic border;  // that result sits on the frame border
	} tok_t;

	// results still inside the window pipeline
	typedef struct packed {
		logic s1;
		logic s2;
	} pend_t;

endpackage

// ----- sv/pwd_ram.sv -----
// pwd_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module pwd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/pwd_div.sv -----
// pwd_div: restoring divider, one quotient bit per cycle.
// Splits a result raster index into row and column. Uses pwd_pkg.
module pwd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pwd_pkg::POS_W-1:0]  dividend,
	input  logic [pwd_pkg::DIM_W-1:0]  divisor,
	output logic                       busy,
	output logic [pwd_pkg::POS_W-1:0]  quotient,
	output logic [pwd_pkg::DIM_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(pwd_pkg::POS_W + 1);

	logic [pwd_pkg::DIM_W-1:0] rem_q;
	logic [pwd_pkg::POS_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic [pwd_pkg::DIM_W:0]   trial;
	logic [pwd_pkg::DIM_W:0]   diff;
	logic                      take;

	always_comb begin
		trial = {rem_q, quo_q[pwd_pkg::POS_W-1]};
		take  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(pwd_pkg::POS_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift one dividend bit in, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[pwd_pkg::DIM_W-1:0] : trial[pwd_pkg::DIM_W-1:0];
			quo_q <= {quo_q[pwd_pkg::POS_W-2:0], take};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- sv/pwd_pos.sv -----
// pwd_pos: input and result position counters, frame bookkeeping and the
// settle sequence after reset or any configuration write. Uses pwd_pkg and pwd_div.
module pwd_pos #(
	parameter int ADDR_W = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  logic [pwd_pkg::DIM_W-1:0] w,
	input  logic [pwd_pkg::DIM_W-1:0] h,
	input  logic                      fire,
	input  logic                      flush,
	output logic                      ready,
	output logic [ADDR_W-1:0]         col,
	output pwd_pkg::tok_t             tok
);

	localparam int XW   = ((ADDR_W > pwd_pkg::DIM_W) ? ADDR_W : pwd_pkg::DIM_W) + 1;
	localparam int ORW1 = pwd_pkg::OROW_W + 1;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;

	logic [1:0]                 state_q;
	logic [pwd_pkg::Q_W-1:0]    q_q;
	logic [pwd_pkg::ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0]          col_q;
	logic [pwd_pkg::POS_W-1:0]  op_q;
	logic [pwd_pkg::OROW_W-1:0] orow_q;
	logic [ADDR_W-1:0]          ocol_q;
	logic [pwd_pkg::TOT_W-1:0]  total_q;

	logic                       div_start;
	logic                       div_busy;
	logic [pwd_pkg::POS_W-1:0]  div_quo;
	logic [pwd_pkg::DIM_W-1:0]  div_rem;

	logic [pwd_pkg::DIM_W:0]    wp1;
	logic                       complete;
	logic                       emit;
	logic                       last;
	logic                       border;
	logic                       wrap;
	logic                       owrap;

	assign div_start = (state_q == ST_MUL);

	pwd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (op_q),
		.divisor   (w),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		wp1      = {1'b0, w} + 1'b1;
		complete = q_q >= pwd_pkg::Q_W'(total_q);
		emit     = q_q >= pwd_pkg::Q_W'(wp1);
		last     = ({1'b0, op_q} + 1'b1) >= total_q;
		border   = (orow_q == '0) || (ORW1'(orow_q) + ORW1'(2) > ORW1'(h)) ||
		           (ocol_q == '0) || (XW'(ocol_q) + XW'(2) > XW'(w));
		wrap     = XW'(col_q) + XW'(1) >= XW'(w);
		owrap    = XW'(ocol_q) + XW'(1) >= XW'(w);

		tok.act    = fire && (complete || (flush == pwd_pkg::OP_PIXEL));
		tok.zero   = complete;
		tok.emit   = emit;
		tok.last   = last;
		tok.border = border;
	end

	assign ready = (state_q == ST_RUN);
	assign col   = col_q;

	// settle: rebuild the linear index and the result row/column for new sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
		end else if (cfg_wr) begin
			state_q <= ST_MUL;
		end else begin
			unique case (state_q)
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: if (!div_busy) begin
					state_q <= ST_RUN;
				end
				ST_RUN: state_q <= ST_RUN;
				default: state_q <= ST_MUL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			op_q    <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
			total_q <= '0;
		end else if (state_q == ST_MUL) begin
			q_q     <= pwd_pkg::Q_W'(row_q) * pwd_pkg::Q_W'(w) + pwd_pkg::Q_W'(col_q);
			total_q <= pwd_pkg::TOT_W'(w) * pwd_pkg::TOT_W'(h);
		end else if (state_q == ST_DIV) begin
			if (!div_busy) begin
				orow_q <= div_quo[pwd_pkg::OROW_W-1:0];
				ocol_q <= ADDR_W'(div_rem);
			end
		end else if (tok.act) begin
			if (emit && last) begin
				q_q    <= '0;
				row_q  <= '0;
				col_q  <= '0;
				op_q   <= '0;
				orow_q <= '0;
				ocol_q <= '0;
			end else begin
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
					q_q   <= q_q - pwd_pkg::Q_W'(col_q) + pwd_pkg::Q_W'(w);
				end else begin
					col_q <= col_q + 1'b1;
					q_q   <= q_q + 1'b1;
				end
				if (emit) begin
					op_q <= op_q + 1'b1;
					if (owrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ----- sv/pwd_judge.sv -----
// pwd_judge: line store read-modify-write with bypass, 3x3 window held as
// column sums and maxima, and the peak decision. Uses pwd_pkg.
module pwd_judge #(
	parameter int ADDR_W = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pwd_pkg::tok_t               tok,
	input  logic [pwd_pkg::DATA_W-1:0]  px,
	input  logic [ADDR_W-1:0]           col,
	input  logic [pwd_pkg::WORD_W-1:0]  rd_data,
	output logic                        wr_en,
	output logic [ADDR_W-1:0]           wr_addr,
	output logic [pwd_pkg::WORD_W-1:0]  wr_data,
	input  logic [pwd_pkg::DATA_W-1:0]  thr,
	input  logic                        lmax,
	output logic                        res_valid,
	output logic [pwd_pkg::DATA_W-1:0]  res_pixel,
	output logic                        res_last,
	output pwd_pkg::pend_t              pend
);

	localparam int CS_W  = pwd_pkg::DATA_W + 2;  // sum of three pixels
	localparam int SUM_W = pwd_pkg::DATA_W + 4;  // sum of nine pixels
	localparam int CMP_W = SUM_W + 1;

	pwd_pkg::tok_t              tok_s1;
	logic [pwd_pkg::DATA_W-1:0] px_s1;
	logic [ADDR_W-1:0]          col_s1;
	logic                       byp_s1;
	logic [pwd_pkg::WORD_W-1:0] bdat_s1;

	logic                       emit_s2;
	logic                       last_s2;
	logic                       border_s2;

	logic [pwd_pkg::DATA_W-1:0] mid_q  [3];
	logic [CS_W-1:0]            csum_q [3];
	logic [pwd_pkg::DATA_W-1:0] cmax_q [3];

	logic [pwd_pkg::WORD_W-1:0] word;
	logic [pwd_pkg::DATA_W-1:0] up;
	logic [pwd_pkg::DATA_W-1:0] md;
	logic [CS_W-1:0]            csum_new;
	logic [pwd_pkg::DATA_W-1:0] cmax_new;

	logic [pwd_pkg::DATA_W-1:0] y;
	logic [pwd_pkg::DATA_W-1:0] mx;
	logic [SUM_W-1:0]           sum;
	logic [SUM_W-1:0]           y9;
	logic [SUM_W-1:0]           thr9;
	logic                       peak;

	// stage 1: line store word arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			byp_s1 <= 1'b0;
		end else begin
			tok_s1 <= tok;
			// same column written now and read now: the read sees stale data
			byp_s1 <= tok_s1.act && tok.act && (col_s1 == col);
		end
	end

	always_ff @(posedge clk) begin
		if (tok.act) begin
			px_s1  <= tok.zero ? pwd_pkg::PIX_NONE : px;
			col_s1 <= col;
		end
		bdat_s1 <= wr_data;
	end

	always_comb begin
		word    = byp_s1 ? bdat_s1 : rd_data;
		md      = word[pwd_pkg::WORD_W-1:pwd_pkg::DATA_W];
		up      = word[pwd_pkg::DATA_W-1:0];
		wr_en   = tok_s1.act;
		wr_addr = col_s1;
		wr_data = {px_s1, md};   // middle line moves up, new pixel becomes middle

		csum_new = CS_W'(up) + CS_W'(md) + CS_W'(px_s1);
		cmax_new = (up > md) ? up : md;
		if (px_s1 > cmax_new) begin
			cmax_new = px_s1;
		end
	end

	// shift the window one column left, new column on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mid_q[i]  <= '0;
				csum_q[i] <= '0;
				cmax_q[i] <= '0;
			end
			emit_s2 <= 1'b0;
		end else begin
			if (tok_s1.act) begin
				mid_q[0]  <= mid_q[1];
				mid_q[1]  <= mid_q[2];
				mid_q[2]  <= md;
				csum_q[0] <= csum_q[1];
				csum_q[1] <= csum_q[2];
				csum_q[2] <= csum_new;
				cmax_q[0] <= cmax_q[1];
				cmax_q[1] <= cmax_q[2];
				cmax_q[2] <= cmax_new;
			end
			emit_s2 <= tok_s1.act && tok_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		last_s2   <= tok_s1.last;
		border_s2 <= tok_s1.border;
	end

	// stage 2: decide
	always_comb begin
		y    = mid_q[1];
		sum  = SUM_W'(csum_q[0]) + SUM_W'(csum_q[1]) + SUM_W'(csum_q[2]);
		y9   = SUM_W'({y, 3'b000}) + SUM_W'(y);
		thr9 = SUM_W'({thr, 3'b000}) + SUM_W'(thr);
		peak = CMP_W'(y9) > (CMP_W'(sum) + CMP_W'(thr9));
		mx   = (cmax_q[0] > cmax_q[1]) ? cmax_q[0] : cmax_q[1];
		if (cmax_q[2] > mx) begin
			mx = cmax_q[2];
		end

		priority if (border_s2) begin
			res_pixel = y;
		end else if (lmax && (y != mx)) begin
			res_pixel = pwd_pkg::PIX_NONE;
		end else if (peak) begin
			res_pixel = pwd_pkg::PIX_PEAK;
		end else begin
			res_pixel = pwd_pkg::PIX_NONE;
		end
	end

	assign res_valid = emit_s2;
	assign res_last  = last_s2;
	assign pend.s1   = tok_s1.act && tok_s1.emit;
	assign pend.s2   = emit_s2;

endmodule

// ----- sv/peak_window_detector.sv -----
// peak_window_detector: top level. Configuration registers, line store RAM,
// output queue. Uses pwd_pkg, pwd_ram, pwd_pos and pwd_judge.
//
//   channel  | direction | transaction when        | carries
//   ---------+-----------+-------------------------+-----------------------------------
//   s_axis   | in        | s_axis_tvalid & tready  | tdata pixel_in, tuser opcode
//   m_axis   | out       | m_axis_tvalid & tready  | tdata pixel_out, tlast last_of_frame
//   cfg      | in        | cfg_valid & cfg_ready   | cfg_index register, cfg_data value
//
// Cycles: one input transaction per clock while tready is high. A result reaches m_axis
// through the line store read, the window update and the decision, which is written
// into the output queue.
// Reset and configuration: after reset and after every configuration write the
// input side holds tready low while the position counters are rebuilt for the
// current frame size (a multiply step, then 23 divider steps).
// Stalls: results wait in a four-entry queue; outside the rebuild tready drops only when
// the queue plus results still in the pipeline would fill it, so the input keeps
// moving while a finished result waits to be taken.
module peak_window_detector #(
	parameter int MAX_LINE_WIDTH = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [pwd_pkg::DATA_W-1:0]        s_axis_tdata,   // [7:0] pixel_in
	input  logic [0:0]                        s_axis_tuser,   // [0] opcode

	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [pwd_pkg::DATA_W-1:0]        m_axis_tdata,   // [7:0] pixel_out
	output logic                              m_axis_tlast,   // last_of_frame

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pwd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pwd_pkg::DIM_W-1:0]         cfg_data
);

	localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);
	// frame_width register is 12 bits, so the usable width never passes its top
	localparam int WCAP   = (MAX_LINE_WIDTH > (1 << pwd_pkg::DIM_W) - 1) ?
	                        (1 << pwd_pkg::DIM_W) - 1 : MAX_LINE_WIDTH;

	// configuration registers
	logic [pwd_pkg::DATA_W-1:0] thr_q;
	logic                       lmax_q;
	logic [pwd_pkg::DIM_W-1:0]  fw_q;
	logic [pwd_pkg::DIM_W-1:0]  fh_q;
	logic                       cfg_wr;

	logic [pwd_pkg::DIM_W-1:0]  w_eff;
	logic [pwd_pkg::DIM_W-1:0]  h_eff;

	logic                       pos_ready;
	logic                       credit_ok;
	logic                       fire;
	logic [ADDR_W-1:0]          col;
	pwd_pkg::tok_t              tok;

	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [pwd_pkg::WORD_W-1:0] wr_data;
	logic [pwd_pkg::WORD_W-1:0] rd_data;

	logic                       res_valid;
	logic [pwd_pkg::DATA_W-1:0] res_pixel;
	logic                       res_last;
	pwd_pkg::pend_t             pend;

	// output queue
	logic [pwd_pkg::DATA_W-1:0]   oq_pix_q  [pwd_pkg::OQ_DEPTH];
	logic                         oq_last_q [pwd_pkg::OQ_DEPTH];
	logic [pwd_pkg::OQ_PTR_W-1:0] oq_wr_q;
	logic [pwd_pkg::OQ_PTR_W-1:0] oq_rd_q;
	logic [pwd_pkg::OQ_CNT_W-1:0] oq_cnt_q;
	logic                         oq_pop;

	// configuration writes are single-cycle, always taken
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= pwd_pkg::THRESHOLD_RESET;
			lmax_q <= 1'b0;
			fw_q   <= pwd_pkg::WIDTH_RESET;
			fh_q   <= pwd_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				pwd_pkg::REG_THRESHOLD: thr_q  <= cfg_data[pwd_pkg::DATA_W-1:0];
				pwd_pkg::REG_LOCAL_MAX: lmax_q <= cfg_data[0];
				pwd_pkg::REG_WIDTH:     fw_q   <= cfg_data;
				pwd_pkg::REG_HEIGHT:    fh_q   <= cfg_data;
			endcase
		end
	end

	// clamp width to 3..line store depth, raise height to at least 3
	always_comb begin
		priority if (fw_q < pwd_pkg::MIN_DIM) begin
			w_eff = pwd_pkg::MIN_DIM;
		end else if (fw_q > pwd_pkg::DIM_W'(WCAP)) begin
			w_eff = pwd_pkg::DIM_W'(WCAP);
		end else begin
			w_eff = fw_q;
		end
		h_eff = (fh_q < pwd_pkg::MIN_DIM) ? pwd_pkg::MIN_DIM : fh_q;
	end

	// hold input when queue plus in-flight results could overflow
	assign credit_ok = (oq_cnt_q + pwd_pkg::OQ_CNT_W'(pend.s1) + pwd_pkg::OQ_CNT_W'(pend.s2))
	                   < pwd_pkg::OQ_CNT_W'(pwd_pkg::OQ_DEPTH);
	assign s_axis_tready = pos_ready && credit_ok;
	assign fire          = s_axis_tvalid && s_axis_tready;

	pwd_pos #(
		.ADDR_W (ADDR_W)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.w      (w_eff),
		.h      (h_eff),
		.fire   (fire),
		.flush  (s_axis_tuser[0]),
		.ready  (pos_ready),
		.col    (col),
		.tok    (tok)
	);

	// upper and middle line stores share one word per column
	pwd_ram #(
		.WIDTH (pwd_pkg::WORD_W),
		.DEPTH (MAX_LINE_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (tok.act),
		.raddr (col),
		.rdata (rd_data)
	);

	pwd_judge #(
		.ADDR_W (ADDR_W)
	) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.px        (s_axis_tdata),
		.col       (col),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.thr       (thr_q),
		.lmax      (lmax_q),
		.res_valid (res_valid),
		.res_pixel (res_pixel),
		.res_last  (res_last),
		.pend      (pend)
	);

	// output queue: push decided results, pop on m_axis transactions
	assign oq_pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (res_valid) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + pwd_pkg::OQ_CNT_W'(res_valid) - pwd_pkg::OQ_CNT_W'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			oq_pix_q[oq_wr_q]  <= res_pixel;
			oq_last_q[oq_wr_q] <= res_last;
		end
	end

	assign m_axis_tvalid = (oq_cnt_q != '0);
	assign m_axis_tdata  = oq_pix_q[oq_rd_q];
	assign m_axis_tlast  = oq_last_q[oq_rd_q];

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench of the peak window detector. Streams small and extreme
// frames through the input channel and checks every output transaction against a
// predictor kept in this file. Depends on pwd_pkg and peak_window_detector.
module tb_top;
	import pwd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int LINE_MAX      = 2048;
	// let the pipeline empty, with margin, before touching the registers
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	// longest quiet stretch of a good run: the receiver hold-off plus the
	// rebuild after a register write; the limit is many times that
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 850;
	localparam int REPORT_CAP    = 100;
	localparam int unsigned NO_CAP = 32'hFFFF_FFFF;

	// idle percentages of sender and receiver, one pair per random phase
	localparam int SEND_IDLE [3] = '{23, 49, 0};
	localparam int RECV_IDLE [3] = '{49, 23, 0};

	typedef enum int {SCENE_NOISE, SCENE_SPARSE, SCENE_FLAT} scene_t;

	typedef struct {
		logic [DATA_W-1:0] pixel;
		logic              last;
	} peak_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata;   // [7:0] pixel_in
	logic [0:0]           s_axis_tuser;   // [0] opcode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [DATA_W-1:0]    m_axis_tdata;   // [7:0] pixel_out
	logic                 m_axis_tlast;   // last_of_frame
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	// predictor copy of the registers and the window state
	logic [DATA_W-1:0] thr_reg;
	logic              local_max_reg;
	logic [DIM_W-1:0]  width_reg;
	logic [DIM_W-1:0]  height_reg;
	logic [DATA_W-1:0] upper_line [LINE_MAX];
	logic [DATA_W-1:0] middle_line [LINE_MAX];
	logic [DATA_W-1:0] win_px [9];
	int unsigned       in_col;
	int unsigned       in_row;
	int unsigned       out_pos;
	bit                frame_closed;

	peak_result_t expected_pixels [$];
	peak_result_t want;

	int unsigned mismatch_count = 0;
	int unsigned item_count     = 0;
	int unsigned stall_count    = 0;
	int unsigned hold_cycles    = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	scene_t      scene = SCENE_NOISE;

	peak_window_detector #(
		.MAX_LINE_WIDTH(LINE_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// width is clamped to 3..line store size, height is raised to three lines
	function automatic int unsigned line_len();
		int unsigned w;
		w = width_reg;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > LINE_MAX) w = LINE_MAX;
		return w;
	endfunction

	function automatic int unsigned line_count();
		return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
	endfunction

	function automatic bit input_complete();
		longint unsigned q;
		q = 64'(in_row) * line_len() + in_col;
		return q >= 64'(line_len()) * line_count();
	endfunction

	// border pixels pass; interior ones are a peak when the center beats the window
	// mean by more than the threshold (scaled by nine), and, if asked, is its maximum
	function automatic logic [DATA_W-1:0] judge_center(int unsigned w, int unsigned h);
		int unsigned       orow;
		int unsigned       ocol;
		int                sum;
		logic [DATA_W-1:0] top;
		orow = out_pos / w;
		ocol = out_pos % w;
		if (orow < 1 || orow + 2 > h || ocol < 1 || ocol + 2 > w) return win_px[4];
		sum = 0;
		top = '0;
		for (int k = 0; k < 9; k++) begin
			sum += win_px[k];
			if (win_px[k] > top) top = win_px[k];
		end
		if (local_max_reg && win_px[4] != top) return PIX_NONE;
		return (9 * int'(win_px[4]) - sum > 9 * int'(thr_reg)) ? PIX_PEAK : PIX_NONE;
	endfunction

	// advance the predictor by one accepted item; return 1 when the block ignores it
	function automatic bit predict_item(logic op, logic [DATA_W-1:0] px_in);
		int unsigned       w;
		int unsigned       h;
		int unsigned       idx;
		longint unsigned   total;
		longint unsigned   q;
		logic [DATA_W-1:0] px;
		logic [DATA_W-1:0] up;
		logic [DATA_W-1:0] mid;
		peak_result_t      res;
		w = line_len();
		h = line_count();
		total = 64'(w) * h;
		q = 64'(in_row) * w + in_col;
		// flush while pixels are still due: no effect at all
		if (q < total && op == OP_FLUSH) return 1'b1;
		// past the frame end every item drains with a zero pixel
		px = (q >= total) ? PIX_NONE : px_in;
		idx = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
		up = upper_line[idx];
		mid = middle_line[idx];
		upper_line[idx] = mid;
		middle_line[idx] = px;
		for (int r = 0; r < 3; r++) begin
			win_px[r * 3]     = win_px[r * 3 + 1];
			win_px[r * 3 + 1] = win_px[r * 3 + 2];
		end
		win_px[2] = up;
		win_px[5] = mid;
		win_px[8] = px;
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row = (in_row + 1) % (1 << ROW_W);
		end else begin
			in_col++;
		end
		// results trail the input by one line plus one pixel
		if (q >= 64'(w) + 1) begin
			res.pixel = judge_center(w, h);
			res.last = (64'(out_pos) + 1 >= total);
			expected_pixels.push_back(res);
			if (res.last) begin
				out_pos = 0;
				in_col = 0;
				in_row = 0;
				frame_closed = 1'b1;
			end else begin
				out_pos++;
			end
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- drivers

	// write one register; call at a falling edge, returns at a later falling edge
	task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [DIM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (reg_index)
			REG_THRESHOLD: thr_reg = value[DATA_W-1:0];
			REG_LOCAL_MAX: local_max_reg = value[0];
			REG_WIDTH:     width_reg = value;
			REG_HEIGHT:    height_reg = value;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// offer one item until the transaction completes; valid is left high so that the
	// next call (or wait_idle) makes the only change at this falling edge
	task automatic send_item(logic op, logic [DATA_W-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		if (!predict_item(op, px)) item_count++;
		@(negedge clk);
	endtask

	// drop valid, wait for every predicted result, then let the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] draw_pixel();
		case (scene)
			SCENE_SPARSE: return ($urandom_range(99) < 8) ? $urandom_range(255, 180)
				: $urandom_range(40);
			SCENE_FLAT:   return ($urandom_range(99) < 5) ? $urandom_range(255)
				: 8'd128 + $urandom_range(3);
			default:      return $urandom_range(255);
		endcase
	endfunction

	// feed pixels until the frame is in, then drain items, until the last result is
	// predicted or max_items items have gone out; a few stray flushes land mid-frame
	task automatic stream_frame(int unsigned max_items);
		int unsigned sent;
		logic        op;
		sent = 0;
		frame_closed = 1'b0;
		while (!frame_closed && sent < max_items) begin
			if (!input_complete())
				op = ($urandom_range(99) < 5) ? OP_FLUSH : OP_PIXEL;
			else
				op = $urandom_range(1) ? OP_FLUSH : OP_PIXEL;
			send_item(op, draw_pixel());
			sent++;
		end
	endtask

	task automatic write_random_config();
		int unsigned      pick;
		logic [DIM_W-1:0] level;
		pick = $urandom_range(99);
		if (pick < 15) level = '0;
		else if (pick < 30) level = 12'd255;
		else if (pick < 70) level = $urandom_range(40);
		else level = DIM_W'($urandom());  // junk above the eight register bits
		write_reg(REG_THRESHOLD, level);
		write_reg(REG_LOCAL_MAX, DIM_W'($urandom()));
		pick = $urandom_range(9);
		if (pick == 0) level = $urandom_range(2);
		else if (pick == 1) level = $urandom_range(40, 13);
		else level = $urandom_range(12, 3);
		write_reg(REG_WIDTH, level);
		pick = $urandom_range(9);
		if (pick == 0) level = $urandom_range(2);
		else if (pick == 1) level = $urandom_range(16, 9);
		else level = $urandom_range(8, 3);
		write_reg(REG_HEIGHT, level);
	endtask

	// ---------------------------------------------------------------- receiver

	// hold off for hold_cycles when asked, otherwise stall at random
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		mismatch_count++;
		// keep the log short when a fault repeats on every result
		if (mismatch_count <= REPORT_CAP) $display("[%0t] MISMATCH %s", $time, what);
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: pixel_out %0d last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata !== want.pixel)
					report_mismatch($sformatf("pixel_out got %0d, predicted %0d",
						m_axis_tdata, want.pixel));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last_of_frame got %0b, predicted %0b",
						m_axis_tlast, want.last));
			end
		end
	end

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// 3x3 frames: one isolated spike with extreme values, a stray flush inside the frame,
	// drain by flush and by pixel, a flush before the next frame, then local-max mode
	// rejecting a bright center that has a brighter neighbor
	task automatic test_directed();
		logic [DATA_W-1:0] spike [9];
		logic [DATA_W-1:0] shadowed [9];
		spike    = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd254};
		shadowed = '{8'd10, 8'd10, 8'd10, 8'd10, 8'd200, 8'd255, 8'd10, 8'd10, 8'd10};
		write_reg(REG_THRESHOLD, 12'd0);
		write_reg(REG_LOCAL_MAX, 12'd0);
		write_reg(REG_WIDTH, 12'd3);
		write_reg(REG_HEIGHT, 12'd3);
		for (int i = 0; i < 9; i++) begin
			send_item(OP_PIXEL, spike[i]);
			if (i == 2) send_item(OP_FLUSH, 8'hFF);
		end
		send_item(OP_FLUSH, 8'h00);
		send_item(OP_PIXEL, 8'd77);
		send_item(OP_FLUSH, 8'hA5);
		send_item(OP_PIXEL, 8'hFF);
		send_item(OP_FLUSH, 8'h5A);
		wait_idle();
		write_reg(REG_THRESHOLD, 12'hA14);
		write_reg(REG_LOCAL_MAX, 12'd1);
		for (int i = 0; i < 9; i++) send_item(OP_PIXEL, shadowed[i]);
		repeat (4) send_item(OP_FLUSH, 8'h00);
		wait_idle();
	endtask

	// out-of-range sizes: the widest line the stores allow, then the tallest frame
	// with a width below the minimum; the first frame also fills every store entry
	task automatic test_size_extremes();
		scene = SCENE_SPARSE;
		write_reg(REG_THRESHOLD, 12'd30);
		write_reg(REG_LOCAL_MAX, 12'd0);
		write_reg(REG_WIDTH, 12'hFFF);
		write_reg(REG_HEIGHT, 12'd0);
		stream_frame(NO_CAP);
		wait_idle();
		scene = SCENE_NOISE;
		write_reg(REG_LOCAL_MAX, 12'd1);
		write_reg(REG_WIDTH, 12'd1);
		write_reg(REG_HEIGHT, 12'hFFF);
		stream_frame(NO_CAP);
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering: the output queue fills and
	// the block must stall its input without losing a result
	task automatic test_backpressure();
		send_idle_pct = 0;
		write_reg(REG_WIDTH, 12'd4);
		write_reg(REG_HEIGHT, 12'd6);
		@(posedge clk);
		hold_cycles = HOLD_CYCLES;
		@(negedge clk);
		stream_frame(NO_CAP);
		wait_idle();
	endtask

	// random frames in three idling phases; some frames are cut short and resized
	// mid-frame, which still has to end and wrap the counters
	task automatic test_random();
		int unsigned target;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			recv_idle_pct = RECV_IDLE[phase];
			target = item_count + RANDOM_ITEMS / 3;
			while (item_count < target) begin
				scene = scene_t'($urandom_range(SCENE_FLAT, SCENE_NOISE));
				write_random_config();
				if ($urandom_range(99) < 15) begin
					stream_frame($urandom_range(line_len() * line_count() - 1, 1));
					wait_idle();
					write_random_config();
				end
				stream_frame(NO_CAP);
				wait_idle();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_PIXEL;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_THRESHOLD;
		cfg_data      = '0;
		send_idle_pct = SEND_IDLE[0];
		recv_idle_pct = RECV_IDLE[0];

		// predictor matches the block after reset
		thr_reg       = THRESHOLD_RESET;
		local_max_reg = 1'b0;
		width_reg     = WIDTH_RESET;
		height_reg    = HEIGHT_RESET;
		in_col        = 0;
		in_row        = 0;
		out_pos       = 0;
		foreach (win_px[k]) win_px[k] = '0;
		foreach (upper_line[k]) begin
			upper_line[k]  = '0;
			middle_line[k] = '0;
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_size_extremes();
		test_backpressure();
		test_random();
		wait_idle();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
